// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the k-nearest-neighbor search block.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/fkt_pkg.sv -----
// Shared types and constants of the filtered k-nearest-neighbor search block.
// Used by the top level, by its port checker and by the testbench; depends on nothing.
package fkt_pkg;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 7;
  localparam int VAL_W      = 16;
  localparam int ID_W       = 32;
  localparam int DIST_W     = 48;
  localparam int CNT_W      = 32;
  localparam int RANK_W     = 4;
  localparam int SQ_W       = 32;
  localparam int KCFG_W     = 5;
  localparam int DCFG_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 120;

  localparam logic [KCFG_W-1:0] K_LIMIT_RST    = 5'd10;
  localparam logic [DCFG_W-1:0] DIM_IN_USE_RST = 8'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_K_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_IN_USE = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_BASE   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Input tdata, lowest field last in the list.
  typedef struct packed {
    logic                    pad;
    logic [ID_W-1:0]         point_id;
    logic signed [VAL_W-1:0] coord_value;
    logic [IDX_W-1:0]        coord_index;
  } in_data_t;

  // Output tdata, lowest field last in the list.
  typedef struct packed {
    logic [3:0]        pad;
    logic [CNT_W-1:0]  satisfied_total;
    logic [DIST_W-1:0] distance;
    logic [ID_W-1:0]   neighbour_id;
    logic [RANK_W-1:0] rank;
  } out_data_t;

endpackage

// ----- rtl/filtered_knn_topk_search.sv -----
// Filtered exact k-nearest-neighbor search under squared L2 distance.
// A finish item passes the read, square and accumulate stages, then loads the emit buffer,
//   which gives one result per cycle while the result side takes them.
// Throughput: one item per cycle; input stalls only while a finish waits for the previous
//   result run to drain from the emit buffer.
// Reset: asynchronous active low; clears the top-K list, counters and pipeline valids.
//   The query store has no reset.
module filtered_knn_topk_search import fkt_pkg::*; #(
  parameter int MAX_K   = 16,
  parameter int MAX_DIM = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // coord_index, coord_value, point_id, pad
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // op, passes_filter
  input  logic                   s_axis_tlast,  // last_coord
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // rank, neighbour_id, distance,
                                                // satisfied_total, pad
  output logic [0:0]             m_axis_tuser,  // empty_res
  output logic                   m_axis_tlast   // last
);

  localparam int HW = $clog2(MAX_K + 1);
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  function automatic logic pair_less(input logic [DIST_W-1:0] da, input logic [ID_W-1:0] ia,
                                     input logic [DIST_W-1:0] db, input logic [ID_W-1:0] ib);
    pair_less = (da < db) || ((da == db) && (ia < ib));
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [KCFG_W-1:0] k_limit_q;
  logic [DCFG_W-1:0] dim_in_use_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_limit_q    <= K_LIMIT_RST;
      dim_in_use_q <= DIM_IN_USE_RST;
    end else if (cfg_valid_i) begin
      priority if (cfg_index_i == CFG_K_LIMIT) begin
        k_limit_q <= cfg_data_i[KCFG_W-1:0];
      end else if (cfg_index_i == CFG_DIM_IN_USE) begin
        dim_in_use_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------- input decode
  in_data_t      in_d;
  op_e           in_op;
  logic          in_pass;
  logic          adv;
  logic          accept;
  logic          in_range;
  logic          in_use;
  logic          q_wr;
  logic [AW-1:0] q_addr;

  assign in_d     = in_data_t'(s_axis_tdata);
  assign in_op    = op_e'(s_axis_tuser[OP_W-1:0]);
  assign in_pass  = s_axis_tuser[OP_W];
  assign accept   = s_axis_tvalid && adv;
  assign in_range = int'(in_d.coord_index) < MAX_DIM;
  assign in_use   = in_range && ({1'b0, in_d.coord_index} < dim_in_use_q);
  assign q_wr     = accept && (in_op == OP_QUERY) && in_range;
  assign q_addr   = AW'(in_d.coord_index);
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------- query store
  logic [VAL_W-1:0] query_mem [MAX_DIM];
  logic [VAL_W-1:0] q_rd_q;

  always_ff @(posedge clk_i) begin
    if (q_wr) begin
      query_mem[q_addr] <= in_d.coord_value;
    end
    if (accept) begin
      q_rd_q <= query_mem[q_addr];
    end
  end

  // ---------------------------------------------------------------- stage 1: read
  logic             p1_valid_q, p1_fin_q;
  logic             p1_use_q, p1_last_q, p1_pass_q;
  logic [ID_W-1:0]  p1_id_q;
  logic [VAL_W-1:0] p1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p1_fin_q   <= 1'b0;
    end else if (adv) begin
      p1_valid_q <= accept && ((in_op == OP_BASE) || (in_op == OP_FINISH));
      p1_fin_q   <= in_op == OP_FINISH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_use_q  <= in_use;
      p1_last_q <= s_axis_tlast;
      p1_pass_q <= in_pass;
      p1_id_q   <= in_d.point_id;
      p1_val_q  <= in_d.coord_value;
    end
  end

  // ---------------------------------------------------------------- stage 2: square
  logic signed [VAL_W:0] diff;
  logic signed [VAL_W:0] diff_abs;
  logic [VAL_W-1:0]      mag;
  logic [SQ_W-1:0]       sq;

  assign diff     = $signed({q_rd_q[VAL_W-1], q_rd_q}) - $signed({p1_val_q[VAL_W-1], p1_val_q});
  assign diff_abs = diff[VAL_W] ? -diff : diff;
  assign mag      = diff_abs[VAL_W-1:0];
  assign sq       = mag * mag;

  logic            p2_valid_q, p2_fin_q;
  logic            p2_use_q, p2_last_q, p2_pass_q;
  logic [ID_W-1:0] p2_id_q;
  logic [SQ_W-1:0] p2_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
      p2_fin_q   <= 1'b0;
    end else if (adv) begin
      p2_valid_q <= p1_valid_q;
      p2_fin_q   <= p1_fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_use_q  <= p1_use_q;
      p2_last_q <= p1_last_q;
      p2_pass_q <= p1_pass_q;
      p2_id_q   <= p1_id_q;
      p2_sq_q   <= sq;
    end
  end

  // ---------------------------------------------------------------- stage 3: accumulate
  logic [DIST_W-1:0] run_q, run_d;
  logic [DIST_W:0]   sum_wide;
  logic [DIST_W-1:0] sum_next;
  logic              p3_cand_q, p3_fin_q;
  logic [DIST_W-1:0] p3_dist_q;
  logic [ID_W-1:0]   p3_id_q;

  assign sum_wide = {1'b0, run_q} + (DIST_W + 1)'(p2_sq_q);

  always_comb begin
    sum_next = run_q;
    if (p2_use_q) begin
      // saturate at the top of the 48-bit range
      sum_next = sum_wide[DIST_W] ? '1 : sum_wide[DIST_W-1:0];
    end
    run_d = run_q;
    if (p2_valid_q) begin
      run_d = (p2_fin_q || p2_last_q) ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      p3_cand_q <= 1'b0;
      p3_fin_q  <= 1'b0;
    end else if (adv) begin
      run_q     <= run_d;
      p3_cand_q <= p2_valid_q && !p2_fin_q && p2_last_q && p2_pass_q;
      p3_fin_q  <= p2_valid_q && p2_fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_dist_q <= sum_next;
      p3_id_q   <= p2_id_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: top-K list
  logic [DIST_W-1:0] dist_q [MAX_K];
  logic [ID_W-1:0]   id_q   [MAX_K];
  logic [DIST_W-1:0] dist_d [MAX_K];
  logic [ID_W-1:0]   id_d   [MAX_K];
  logic [HW-1:0]     held_q, held_d;
  logic [CNT_W-1:0]  pass_q;
  logic [HW-1:0]     k_eff;
  logic [HW-1:0]     live;
  logic [DIST_W-1:0] last_dist;
  logic              fill, evict, admit;
  logic [MAX_K-1:0]  keep;

  always_comb begin
    if (k_limit_q == '0) begin
      k_eff = HW'(1);
    end else if (int'(k_limit_q) > MAX_K) begin
      k_eff = HW'(MAX_K);
    end else begin
      k_eff = HW'(k_limit_q);
    end
  end

  always_comb begin
    logic              prev_keep;
    logic [DIST_W-1:0] prev_dist;
    logic [ID_W-1:0]   prev_id;
    last_dist = '0;
    for (int j = 0; j < MAX_K; j++) begin
      if (j + 1 == int'(held_q)) begin
        last_dist = dist_q[j];
      end
    end
    fill  = held_q < k_eff;
    evict = !fill && (held_q != '0) && (p3_dist_q < last_dist);
    admit = p3_cand_q && (fill || evict);
    // entries that stay in the list ahead of the insertion
    live   = fill ? held_q : held_q - HW'(1);
    held_d = fill ? held_q + HW'(1) : held_q;

    prev_keep = 1'b1;
    prev_dist = '0;
    prev_id   = '0;
    for (int j = 0; j < MAX_K; j++) begin
      keep[j] = (j < int'(live)) && !pair_less(p3_dist_q, p3_id_q, dist_q[j], id_q[j]);
      if (keep[j]) begin
        dist_d[j] = dist_q[j];
        id_d[j]   = id_q[j];
      end else if (prev_keep) begin
        dist_d[j] = p3_dist_q;
        id_d[j]   = p3_id_q;
      end else begin
        dist_d[j] = prev_dist;
        id_d[j]   = prev_id;
      end
      prev_keep = keep[j];
      prev_dist = dist_q[j];
      prev_id   = id_q[j];
    end
  end

  logic              load;
  logic [HW-1:0]     emit_cnt_q;
  logic              busy;

  assign busy = emit_cnt_q != '0;
  // hold the whole pipeline while a finish waits for the emit buffer
  assign adv  = !(p3_fin_q && busy);
  assign load = adv && p3_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else if (load) begin
      held_q <= '0;
      pass_q <= '0;
    end else if (adv && p3_cand_q) begin
      pass_q <= pass_q + CNT_W'(1);
      if (admit) begin
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && admit) begin
      for (int j = 0; j < MAX_K; j++) begin
        dist_q[j] <= dist_d[j];
        id_q[j]   <= id_d[j];
      end
    end
  end

  // ---------------------------------------------------------------- emit buffer
  logic [DIST_W-1:0] buf_dist_q [MAX_K];
  logic [ID_W-1:0]   buf_id_q   [MAX_K];
  logic [CNT_W-1:0]  buf_total_q;
  logic              buf_empty_q;
  logic [RANK_W-1:0] rank_q;
  logic              out_take;

  assign out_take = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_cnt_q  <= '0;
      rank_q      <= '0;
      buf_empty_q <= 1'b0;
    end else if (load) begin
      emit_cnt_q  <= (held_q == '0) ? HW'(1) : held_q;
      rank_q      <= '0;
      buf_empty_q <= held_q == '0;
    end else if (out_take) begin
      emit_cnt_q <= emit_cnt_q - HW'(1);
      rank_q     <= rank_q + RANK_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_total_q <= pass_q;
      for (int j = 0; j < MAX_K; j++) begin
        buf_dist_q[j] <= dist_q[j];
        buf_id_q[j]   <= id_q[j];
      end
    end else if (out_take) begin
      // advance the next entry to the head
      for (int j = 0; j < MAX_K - 1; j++) begin
        buf_dist_q[j] <= buf_dist_q[j+1];
        buf_id_q[j]   <= buf_id_q[j+1];
      end
    end
  end

  out_data_t od;

  always_comb begin
    od.pad             = '0;
    od.rank            = buf_empty_q ? '0 : rank_q;
    od.neighbour_id    = buf_empty_q ? '0 : buf_id_q[0];
    od.distance        = buf_empty_q ? '0 : buf_dist_q[0];
    od.satisfied_total = buf_empty_q ? '0 : buf_total_q;
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tlast  = emit_cnt_q == HW'(1);
  assign m_axis_tuser  = buf_empty_q;
  assign m_axis_tdata  = od;

endmodule

// ----- rtl/fkt_checker.sv -----
// Port checker for the k-nearest-neighbor search block, bound to its top level.
// Depends on fkt_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module fkt_checker import fkt_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser,
  input logic                   m_axis_tlast
);

  out_data_t od;
  logic      take_mid;

  assign od       = out_data_t'(m_axis_tdata);
  assign take_mid = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

  // an empty-list result stands alone and carries only zeros
  `ASSERT_IMPL(a_empty_alone, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == '0))

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // the rest of a run follows at once with the next rank
  `ASSERT_NEXT(a_rank_step, clk_i, rst_ni, take_mid, m_axis_tvalid && (od.rank == RANK_W'($past(od.rank) + 1'b1)))

  // every result of a run reports the same pass count
  `ASSERT_NEXT(a_total_same, clk_i, rst_ni, take_mid, od.satisfied_total == $past(od.satisfied_total))

endmodule

bind filtered_knn_topk_search fkt_checker u_fkt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/filtered_knn_topk_search_tb.sv -----
// Self-checking testbench for the filtered k-nearest-neighbor search block.
// Predicts every result run with a scoreboard class; needs fkt_pkg and the top level.
module filtered_knn_topk_search_tb;
  import fkt_pkg::*;

  localparam int                MAX_K       = 16;
  localparam int                MAX_DIM     = 128;
  localparam int                QLOAD       = 16;
  localparam logic [DIST_W-1:0] SUM_MAX     = '1;
  localparam int                QUIET_LIMIT = 2000;
  localparam int                DRAIN_WAIT  = 24;

  typedef struct packed {
    op_e                     op;
    logic [IDX_W-1:0]        coord_index;
    logic signed [VAL_W-1:0] coord_value;
    logic [ID_W-1:0]         point_id;
    logic                    passes_filter;
    logic                    last_coord;
  } knn_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   neighbour_id;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  satisfied_total;
    logic              empty_res;
    logic              last;
  } knn_result_t;

  typedef enum int {COORD_MATCH, COORD_FAR, COORD_RANDOM} coord_mode_e;

  class knn_scoreboard;
    logic signed [VAL_W-1:0] query_mem [MAX_DIM];
    logic [DIST_W-1:0]       run_sum;
    logic [DIST_W-1:0]       top_dist [MAX_K];
    logic [ID_W-1:0]         top_id [MAX_K];
    int unsigned             held;
    logic [CNT_W-1:0]        passed;
    logic [KCFG_W-1:0]       k_reg;
    logic [DCFG_W-1:0]       dim_reg;
    knn_result_t             pending [$];
    int                      errors;

    function new();
      run_sum = '0;
      held    = 0;
      passed  = '0;
      k_reg   = K_LIMIT_RST;
      dim_reg = DIM_IN_USE_RST;
      errors  = 0;
      foreach (top_dist[i]) begin
        top_dist[i] = '0;
        top_id[i]   = '0;
      end
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_K_LIMIT) k_reg = data[KCFG_W-1:0];
      else if (idx == CFG_DIM_IN_USE) dim_reg = data[DCFG_W-1:0];
    endfunction

    function void insert_entry(logic [DIST_W-1:0] d, logic [ID_W-1:0] id);
      int pos;
      pos = held;
      while (pos > 0 && (d < top_dist[pos-1] || (d == top_dist[pos-1] && id < top_id[pos-1])))
      begin
        top_dist[pos] = top_dist[pos-1];
        top_id[pos]   = top_id[pos-1];
        pos--;
      end
      top_dist[pos] = d;
      top_id[pos]   = id;
      held++;
    endfunction

    function void offer_point(logic [DIST_W-1:0] d, logic [ID_W-1:0] id);
      int unsigned k_eff;
      k_eff = (k_reg == 0) ? 1 : (k_reg > MAX_K) ? MAX_K : k_reg;
      if (held < k_eff) begin
        insert_entry(d, id);
      end else if (held > 0 && d < top_dist[held-1]) begin
        // evict the largest entry
        held--;
        insert_entry(d, id);
      end
    endfunction

    function void emit_list();
      knn_result_t r;
      if (held == 0) begin
        r = '0;
        r.empty_res = 1'b1;
        r.last = 1'b1;
        pending.push_back(r);
      end else begin
        for (int i = 0; i < held; i++) begin
          r.rank            = RANK_W'(i);
          r.neighbour_id    = top_id[i];
          r.distance        = top_dist[i];
          r.satisfied_total = passed;
          r.empty_res       = 1'b0;
          r.last            = (i == held - 1);
          pending.push_back(r);
        end
      end
      foreach (top_dist[i]) begin
        top_dist[i] = '0;
        top_id[i]   = '0;
      end
      held    = 0;
      passed  = '0;
      run_sum = '0;
    endfunction

    function void note_item(knn_item_t it);
      int          dim_eff;
      int          diff;
      longint      mag;
      logic [63:0] sq;
      logic [63:0] acc;
      dim_eff = (dim_reg < MAX_DIM) ? dim_reg : MAX_DIM;
      case (it.op)
        OP_QUERY: query_mem[it.coord_index] = it.coord_value;
        OP_BASE: begin
          if (it.coord_index < dim_eff) begin
            diff = query_mem[it.coord_index] - it.coord_value;
            mag  = (diff < 0) ? -diff : diff;
            sq   = mag * mag;
            acc  = {16'b0, run_sum} + sq;
            run_sum = (acc > SUM_MAX) ? SUM_MAX : acc[DIST_W-1:0];
          end
          if (it.last_coord) begin
            if (it.passes_filter) begin
              passed++;
              offer_point(run_sum, it.point_id);
            end
            run_sum = '0;
          end
        end
        OP_FINISH: emit_list();
        default: ;
      endcase
    endfunction

    function void check_result(knn_result_t got);
      knn_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: rank %0d id %h dist %h total %0d empty %b last %b",
                   got.rank, got.neighbour_id, got.distance, got.satisfied_total,
                   got.empty_res, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.rank !== want.rank || got.neighbour_id !== want.neighbour_id ||
          got.distance !== want.distance || got.satisfied_total !== want.satisfied_total ||
          got.empty_res !== want.empty_res || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: expected rank %0d id %h dist %h total %0d empty %b last %b",
                   want.rank, want.neighbour_id, want.distance, want.satisfied_total,
                   want.empty_res, want.last);
          $display("                 actual   rank %0d id %h dist %h total %0d empty %b last %b",
                   got.rank, got.neighbour_id, got.distance, got.satisfied_total,
                   got.empty_res, got.last);
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  knn_scoreboard sb = new();
  bit            idle_on = 1'b1;
  int            quiet_cycles = 0;

  filtered_knn_topk_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // end the run when no channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("filtered_knn_topk_search_tb failed");
      $finish;
    end
  end

  // result side: random stall before each item while idle_on is set, then hold ready until it moves
  initial begin
    int          stall;
    out_data_t   od;
    knn_result_t got;
    forever begin
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      od = m_axis_tdata;
      got.rank            = od.rank;
      got.neighbour_id    = od.neighbour_id;
      got.distance        = od.distance;
      got.satisfied_total = od.satisfied_total;
      got.empty_res       = m_axis_tuser[0];
      got.last            = m_axis_tlast;
      sb.check_result(got);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] k, input logic [CFG_DATA_W-1:0] dim);
    write_reg(CFG_K_LIMIT, k);
    write_reg(CFG_DIM_IN_USE, dim);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(input knn_item_t it);
    int       gap;
    in_data_t d;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    d.pad         = 1'b0;
    d.point_id    = it.point_id;
    d.coord_value = it.coord_value;
    d.coord_index = it.coord_index;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {it.passes_filter, it.op};
    s_axis_tlast  <= it.last_coord;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  task automatic send_query(input int idx, input logic signed [VAL_W-1:0] val);
    knn_item_t it;
    it = '0;
    it.op          = OP_QUERY;
    it.coord_index = IDX_W'(idx);
    it.coord_value = val;
    it.point_id    = $urandom;
    send_item(it);
  endtask

  task automatic send_finish();
    knn_item_t it;
    it.op            = OP_FINISH;
    it.coord_index   = IDX_W'($urandom);
    it.coord_value   = VAL_W'($urandom);
    it.point_id      = $urandom;
    it.passes_filter = 1'($urandom);
    it.last_coord    = 1'($urandom);
    send_item(it);
  endtask

  // stream one base point; only its final coordinate carries id and filter flag
  task automatic send_point(input logic [ID_W-1:0] pid, input logic pass, input int ncoord,
                            input int span, input coord_mode_e mode);
    knn_item_t               it;
    logic signed [VAL_W-1:0] q;
    for (int c = 0; c < ncoord; c++) begin
      it.op          = OP_BASE;
      it.coord_index = (mode == COORD_RANDOM) ? IDX_W'($urandom_range(0, QLOAD - 1)) :
                                                IDX_W'(c % span);
      q = sb.query_mem[it.coord_index];
      case (mode)
        COORD_MATCH: it.coord_value = q;
        COORD_FAR:   it.coord_value = q[VAL_W-1] ? 16'sh7fff : 16'sh8000;
        default:     it.coord_value = VAL_W'($urandom);
      endcase
      it.last_coord    = (c == ncoord - 1);
      it.point_id      = it.last_coord ? pid : $urandom;
      it.passes_filter = it.last_coord ? pass : 1'($urandom);
      send_item(it);
    end
  endtask

  // drain all expected results, then let trailing items leave the pipeline
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [CFG_DATA_W-1:0] k, input logic [CFG_DATA_W-1:0] dim);
    int        sent;
    int        sel;
    int        len;
    knn_item_t it;
    configure(k, dim);
    idle_on = ($urandom_range(0, 3) != 0);
    sent = 0;
    while (sent < 6) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        len = $urandom_range(1, 4);
        send_point(($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom),
                   $urandom_range(0, 3) != 0, len, MAX_DIM,
                   ($urandom_range(0, 3) == 0) ? COORD_MATCH : COORD_RANDOM);
        sent += len;
      end else if (sel < 82) begin
        send_finish();
        sent++;
      end else if (sel < 90) begin
        send_query($urandom_range(0, MAX_DIM - 1), VAL_W'($urandom));
        sent++;
      end else begin
        // stray item: any op, any flags, may break the current point
        it.op            = op_e'($urandom_range(0, 3));
        it.coord_index   = IDX_W'($urandom_range(0, QLOAD - 1));
        it.coord_value   = VAL_W'($urandom);
        it.point_id      = $urandom;
        it.passes_filter = 1'($urandom);
        it.last_coord    = 1'($urandom);
        send_item(it);
        if (it.op != OP_NONE) sent++;
      end
    end
    // leave entries held now and then so the next setting sees them
    if ($urandom_range(0, 1)) send_finish();
    settle();
  endtask

  initial begin
    knn_item_t it;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load the query entries that base points use; the first four hold the extremes
    for (int i = 0; i < QLOAD; i++)
      send_query(i, (i < 4) ? ((i % 2) ? 16'sh7fff : 16'sh8000) : VAL_W'($urandom));
    settle();

    configure(3, 4);
    send_finish();
    it = '0;
    it.op = OP_NONE;
    it.point_id = '1;
    it.passes_filter = 1'b1;
    it.last_coord = 1'b1;
    send_item(it);
    // equal far distances ordered by id, coordinates past the dimension ignored
    send_point(32'hffff_ffff, 1'b1, 6, 6, COORD_FAR);
    send_point(32'h0, 1'b1, 6, 6, COORD_FAR);
    send_point(32'h7, 1'b0, 4, 4, COORD_MATCH);
    send_point(32'h9, 1'b1, 4, 4, COORD_MATCH);
    // list full: a tie with the largest entry stays out
    send_point(32'h3, 1'b1, 4, 4, COORD_FAR);
    send_finish();
    settle();

    // k of zero acts as one, dimension of zero gives distance zero
    configure(0, 0);
    send_point(32'h55, 1'b1, 3, 4, COORD_FAR);
    send_point(32'h11, 1'b1, 2, 4, COORD_RANDOM);
    send_finish();
    settle();

    // oversized k and dimension, items back to back with large distances
    configure(31, 255);
    idle_on = 1'b0;
    send_point(32'hdead_beef, 1'b1, 8, 4, COORD_FAR);
    send_point(32'h1, 1'b1, 2, 4, COORD_FAR);
    send_finish();
    settle();

    // fill sixteen entries, then lower k while they are held
    configure(16, 128);
    idle_on = 1'b1;
    for (int i = 0; i < MAX_K; i++)
      send_point($urandom, 1'b1, 1, MAX_DIM, COORD_RANDOM);
    settle();
    configure(2, 128);
    send_point(32'h42, 1'b1, 2, 2, COORD_MATCH);
    send_point(32'h43, 1'b1, 4, 4, COORD_FAR);
    send_finish();
    settle();

    random_phase(16, 1);
    random_phase(1, 128);
    for (int p = 0; p < 3; p++)
      random_phase($urandom_range(1, 16),
                   ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(1, 8));
    send_finish();
    settle();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("filtered_knn_topk_search_tb passed");
    else
      $display("filtered_knn_topk_search_tb failed");
    $finish;
  end

endmodule
